>>> rtl/ftd_pkg.sv
`default_nettype none

package ftd_pkg;

  localparam int KIND_W      = 2;
  localparam int TASK_W      = 16;
  localparam int CORE_W      = 3;
  localparam int CFG_W       = 4;
  localparam int MAX_RESULTS = 8;
  localparam int NCNT_W      = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // input kinds
  localparam logic [KIND_W-1:0] K_RUN     = 2'd0;
  localparam logic [KIND_W-1:0] K_DONE    = 2'd1;
  localparam logic [KIND_W-1:0] K_STOP    = 2'd2;
  localparam logic [KIND_W-1:0] K_UNKNOWN = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] RK_DISPATCH = 2'd0;
  localparam logic [KIND_W-1:0] RK_DONE     = 2'd1;
  localparam logic [KIND_W-1:0] RK_FAILED   = 2'd2;
  localparam logic [KIND_W-1:0] RK_REJECT   = 2'd3;

  typedef struct packed {
    logic capture;
    logic exec;
    logic disp_rd;
    logic disp_emit;
    logic stop_rd;
    logic stop_emit;
    logic stop_final;
  } cmd_t;

  typedef struct packed {
    logic stopped;
    logic is_stop;
    logic busy_any;
    logic out_free;
    logic disp_more;
    logic kill_last;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/ftd_ram.sv
`default_nettype none

module ftd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ftd_ctrl.sv
`default_nettype none

module ftd_ctrl
  import ftd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DRD  = 3'd2;
  localparam logic [2:0] S_DWR  = 3'd3;
  localparam logic [2:0] S_SRD  = 3'd4;
  localparam logic [2:0] S_SWR  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.stopped) begin
          state_next = S_IDLE;
        end else if (sts.is_stop) begin
          if (sts.busy_any) begin
            cmd.exec   = 1'b1;
            state_next = S_SRD;
          end else begin
            cmd.stop_final = 1'b1;
            state_next     = S_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_DRD;
        end
      end
      S_DRD: begin
        if (sts.disp_more) begin
          cmd.disp_rd = 1'b1;
          state_next  = S_DWR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DWR: begin
        if (sts.out_free) begin
          cmd.disp_emit = 1'b1;
          state_next    = S_DRD;
        end
      end
      S_SRD: begin
        cmd.stop_rd = 1'b1;
        state_next  = S_SWR;
      end
      S_SWR: begin
        if (sts.out_free) begin
          cmd.stop_emit = 1'b1;
          if (sts.kill_last) begin
            cmd.stop_final = 1'b1;
            state_next     = S_IDLE;
          end else begin
            state_next = S_SRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ftd_dpath.sv
`default_nettype none

module ftd_dpath
  import ftd_pkg::*;
#(
  parameter int NUM_CORES   = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [TASK_W-1:0] task_id,
  input  wire logic [CORE_W-1:0] done_core,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [KIND_W-1:0]      result_kind,
  output logic [TASK_W-1:0]      result_task,
  output logic [CORE_W-1:0]      result_core,
  output logic                   last_result
);

  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CIDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  function automatic logic [NUM_CORES-1:0] pool_of(input logic [CFG_W-1:0] n);
    logic [NUM_CORES-1:0] m;
    for (int i = 0; i < NUM_CORES; i++) begin
      m[i] = (i == 0) || (int'(n) > i);
    end
    return m;
  endfunction

  function automatic logic [CIDX_W-1:0] lowest_idx(input logic [NUM_CORES-1:0] m);
    logic [CIDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_CORES - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = CIDX_W'(i);
      end
    end
    return idx;
  endfunction

  // state
  logic [CFG_W-1:0]     cores_in_use;
  logic [NUM_CORES-1:0] idle_mask;
  logic [NUM_CORES-1:0] kill_mask;
  logic [QA_W-1:0]      fifo_head;
  logic [QC_W-1:0]      fifo_count;
  logic                 stopped;
  logic [NCNT_W-1:0]    n_res;

  // captured event
  logic [KIND_W-1:0] cap_kind;
  logic [TASK_W-1:0] cap_task;
  logic [CORE_W-1:0] cap_core;

  logic [NUM_CORES-1:0] busy;
  logic [NUM_CORES-1:0] done_hot;
  logic                 done_ok;
  logic [NUM_CORES-1:0] idle_hot;
  logic [CIDX_W-1:0]    idle_idx;
  logic [NUM_CORES-1:0] kill_hot;
  logic [CIDX_W-1:0]    kill_idx;
  logic                 full;
  logic [QA_W:0]        tail_sum;
  logic [QA_W-1:0]      fifo_tail;
  logic [QA_W-1:0]      head_inc;
  logic                 push;
  logic [TASK_W-1:0]    fifo_rdata;
  logic [TASK_W-1:0]    task_rdata;
  logic [NCNT_W-1:0]    n_inc;
  logic                 disp_last;
  logic                 kill_last;

  logic              em_valid;
  logic [KIND_W-1:0] em_kind;
  logic [TASK_W-1:0] em_task;
  logic [CORE_W-1:0] em_core;
  logic              em_last;

  assign busy = pool_of(cores_in_use) & ~idle_mask;

  always_comb begin
    for (int i = 0; i < NUM_CORES; i++) begin
      done_hot[i] = (i < (1 << CORE_W)) && (cap_core == CORE_W'(i));
    end
  end

  assign done_ok  = |(done_hot & busy);
  assign idle_hot = idle_mask & (~idle_mask + NUM_CORES'(1));
  assign idle_idx = lowest_idx(idle_mask);
  assign kill_hot = kill_mask & (~kill_mask + NUM_CORES'(1));
  assign kill_idx = lowest_idx(kill_mask);

  assign full      = (fifo_count == QC_W'(QUEUE_DEPTH));
  assign tail_sum  = (QA_W+1)'(fifo_head) + (QA_W+1)'(fifo_count);
  assign fifo_tail = (tail_sum >= (QA_W+1)'(QUEUE_DEPTH))
                   ? QA_W'(tail_sum - (QA_W+1)'(QUEUE_DEPTH)) : QA_W'(tail_sum);
  assign head_inc  = (fifo_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : fifo_head + QA_W'(1);
  assign push      = cmd.exec && (cap_kind == K_RUN) && !full;

  assign n_inc     = n_res + NCNT_W'(1);
  assign disp_last = !((fifo_count > QC_W'(1)) && ((idle_mask & ~idle_hot) != '0)
                       && (n_inc < NCNT_W'(MAX_RESULTS)));
  assign kill_last = ((kill_mask & ~kill_hot) == '0) || (n_inc == NCNT_W'(MAX_RESULTS));

  assign sts.stopped   = stopped;
  assign sts.is_stop   = (cap_kind == K_STOP);
  assign sts.busy_any  = (busy != '0);
  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.disp_more = (fifo_count != '0) && (idle_mask != '0)
                         && (n_res < NCNT_W'(MAX_RESULTS));
  assign sts.kill_last = kill_last;

  ftd_ram #(.WIDTH(TASK_W), .DEPTH(QUEUE_DEPTH), .ADDR_W(QA_W)) u_fifo_ram (
    .clk   (clk),
    .we    (push),
    .waddr (fifo_tail),
    .wdata (cap_task),
    .re    (cmd.disp_rd),
    .raddr (fifo_head),
    .rdata (fifo_rdata)
  );

  ftd_ram #(.WIDTH(TASK_W), .DEPTH(NUM_CORES), .ADDR_W(CIDX_W)) u_task_ram (
    .clk   (clk),
    .we    (cmd.disp_emit),
    .waddr (idle_idx),
    .wdata (fifo_rdata),
    .re    (cmd.stop_rd),
    .raddr (kill_idx),
    .rdata (task_rdata)
  );

  // result select
  always_comb begin
    em_valid = 1'b0;
    em_kind  = RK_REJECT;
    em_task  = cap_task;
    em_core  = '0;
    em_last  = !((fifo_count != '0) && (idle_mask != '0));
    if (cmd.exec) begin
      unique case (cap_kind)
        K_RUN: begin
          em_valid = full;
        end
        K_DONE: begin
          em_valid = 1'b1;
          if (done_ok) begin
            em_kind = RK_DONE;
            em_core = cap_core;
            em_last = (fifo_count == '0);
          end
        end
        K_STOP: begin
          em_valid = 1'b0;
        end
        default: begin
          em_valid = 1'b1;
        end
      endcase
    end
    if (cmd.disp_emit) begin
      em_valid = 1'b1;
      em_kind  = RK_DISPATCH;
      em_task  = fifo_rdata;
      em_core  = CORE_W'(idle_idx);
      em_last  = disp_last;
    end
    if (cmd.stop_emit) begin
      em_valid = 1'b1;
      em_kind  = RK_FAILED;
      em_task  = task_rdata;
      em_core  = CORE_W'(kill_idx);
      em_last  = kill_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_kind <= kind;
      cap_task <= task_id;
      cap_core <= done_core;
    end
    if (em_valid) begin
      result_kind <= em_kind;
      result_task <= em_task;
      result_core <= em_core;
      last_result <= em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cores_in_use <= CFG_RESET;
      idle_mask    <= pool_of(CFG_RESET);
      kill_mask    <= '0;
      fifo_head    <= '0;
      fifo_count   <= '0;
      stopped      <= 1'b0;
      n_res        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cores_in_use <= cfg_data;
        if (!stopped) begin
          idle_mask <= pool_of(cfg_data);
        end
      end
      if (cmd.capture) begin
        n_res <= '0;
      end
      if (push) begin
        fifo_count <= fifo_count + QC_W'(1);
      end
      if (cmd.exec && (cap_kind == K_DONE) && done_ok) begin
        idle_mask <= idle_mask | done_hot;
      end
      if (cmd.exec && (cap_kind == K_STOP)) begin
        kill_mask <= busy;
      end
      if (cmd.disp_emit) begin
        fifo_head  <= head_inc;
        fifo_count <= fifo_count - QC_W'(1);
        idle_mask  <= idle_mask & ~idle_hot;
      end
      if (cmd.stop_emit) begin
        kill_mask <= kill_mask & ~kill_hot;
      end
      if (cmd.stop_final) begin
        idle_mask  <= '0;
        fifo_head  <= '0;
        fifo_count <= '0;
        stopped    <= 1'b1;
      end
      if (em_valid) begin
        n_res     <= n_inc;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/fifo_task_to_idle_core_dispatcher_core.sv
// Timing: a done report or reject is formed in EXEC from the captured event and
// registered at the output; a dispatch or failed report reads its RAM, then emits,
// and read and emit repeat for each further one; output stalls hold each emit.
// One event at a time, events after a stop give no result, at most 8 results each.
// Reset (rst, synchronous): empty queue, cores 0..7 idle, stop flag cleared;
// the queue and task tables hold no reset value and need no clearing pass.
`default_nettype none

module fifo_task_to_idle_core_dispatcher_core
  import ftd_pkg::*;
#(
  parameter int NUM_CORES   = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // event channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [TASK_W-1:0] task_id,
  input  wire logic [CORE_W-1:0] done_core,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [KIND_W-1:0]      result_kind,
  output logic [TASK_W-1:0]      result_task,
  output logic [CORE_W-1:0]      result_core,
  output logic                   last_result,
  // pool size register
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cores_in_use
);

  cmd_t cmd;
  sts_t sts;

  // register is always writable; software writes only while the block is quiet
  assign cfg_ready = 1'b1;

  // Controller: one event at a time. EXEC handles the event itself (queue push,
  // core release, reject, or loading the kill set for a stop), then the
  // dispatch loop or the stop walk runs until nothing is left or 8 results.
  ftd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: waiting queue and per-core task table in RAM, idle/kill masks with
  // lowest-set-bit pickers, and the output register that decouples the result
  // transfer from the next input transfer.
  ftd_dpath #(
    .NUM_CORES   (NUM_CORES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cores_in_use),
    .kind        (kind),
    .task_id     (task_id),
    .done_core   (done_core),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .result_task (result_task),
    .result_core (result_core),
    .last_result (last_result)
  );

endmodule

`default_nettype wire

>>> rtl/ftd_checker.sv
`default_nettype none

module ftd_checker
  import ftd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [KIND_W-1:0] result_kind,
  input wire logic [TASK_W-1:0] result_task,
  input wire logic [CORE_W-1:0] result_core,
  input wire logic              last_result
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind)
      && $stable(result_task) && $stable(result_core) && $stable(last_result))
    else $error("result changed while stalled");

  // one event at a time: input closes after each transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // results only come out of event processing
  a_res_from_event: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an event in progress");

  a_reject_core: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RK_REJECT) |-> (result_core == '0))
    else $error("rejected result names a core");

endmodule

bind fifo_task_to_idle_core_dispatcher_core ftd_checker u_ftd_checker (.*);

`default_nettype wire
